// ===== hdl/scpa_pkg.sv =====
// Shared types and constants for the size-class pool allocator.
package scpa_pkg;

	localparam int ADDR_W     = 19;
	localparam int SIZE_W     = 16;
	localparam int CLSB_W     = 15;
	localparam int CLS_FULL_W = 17;
	localparam int CLS_IDX_W  = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERSIZE = 3'd1,
		ST_WRONG    = 3'd2,
		ST_OOM      = 3'd3,
		ST_UNUSED   = 3'd4
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] block_addr;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] alloc_addr;
		logic [CLSB_W-1:0] class_bytes;
	} rsp_t;

	typedef struct packed {
		logic                  is_free;
		status_t               pre;
		logic [CLS_IDX_W-1:0]  idx;
		logic [CLS_FULL_W-1:0] cls_bytes;
		logic [ADDR_W-1:0]     addr;
	} cls_item_t;

endpackage

// ===== hdl/size_class_pool_allocator.sv =====
// Top level of the size-class pool allocator.
// Requests pass through the queue to the back end, which registers each response.
// Throughput: 1 request per cycle unless the output stalls; a free-stack allocate
// holds the back end in a pop state for the registered read of the link memory.
// Reset: all free stacks empty, no chunk claimed, all classes unused; link memory
// contents are not cleared and need no clearing pass.
module size_class_pool_allocator #(
	parameter int CHUNK_BYTES = 32768,
	parameter int NUM_CHUNKS  = 16,
	parameter int MIN_BLOCK   = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  scpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output scpa_pkg::rsp_t rsp
);
	import scpa_pkg::*;

	logic      fq_valid;
	logic      fq_ready;
	cls_item_t fq_item;
	logic      qb_valid;
	logic      qb_ready;
	cls_item_t qb_item;

	scpa_front #(
		.CHUNK_BYTES(CHUNK_BYTES),
		.MIN_BLOCK  (MIN_BLOCK)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.item_valid(fq_valid),
		.item_ready(fq_ready),
		.item      (fq_item)
	);

	scpa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_data (fq_item),
		.rd_valid(qb_valid),
		.rd_ready(qb_ready),
		.rd_data (qb_item)
	);

	scpa_back #(
		.CHUNK_BYTES(CHUNK_BYTES),
		.NUM_CHUNKS (NUM_CHUNKS),
		.MIN_BLOCK  (MIN_BLOCK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(qb_valid),
		.item_ready(qb_ready),
		.item      (qb_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.alloc_addr == '0))
		else $error("nonzero address on failed response");

	a_no_class_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.status == ST_OVERSIZE) || (rsp.status == ST_WRONG))
		|-> (rsp.class_bytes == '0))
		else $error("class size reported without a class");

	a_class_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0(rsp.class_bytes))
		else $error("class size not a power of two");

	a_queue_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!fq_ready |-> !req_ready)
		else $error("request taken while queue full");

endmodule

// ===== hdl/scpa_front.sv =====
// Front end: size classification of incoming requests.
module scpa_front #(
	parameter int CHUNK_BYTES = 32768,
	parameter int MIN_BLOCK   = 8
) (
	input  logic                 req_valid,
	output logic                 req_ready,
	input  scpa_pkg::req_t       req,
	output logic                 item_valid,
	input  logic                 item_ready,
	output scpa_pkg::cls_item_t  item
);
	import scpa_pkg::*;

	localparam int LOG_MIN = $clog2(MIN_BLOCK);
	localparam int CMP_W   = 22;

	logic [SIZE_W-1:0]     size_m1;
	logic [4:0]            clg;
	logic [4:0]            shamt;
	logic [4:0]            kidx;
	logic [CLS_FULL_W-1:0] cls;
	logic                  oversize;
	logic                  wrong;

	always_comb begin
		size_m1 = req.req_size - SIZE_W'(1);
		clg = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (size_m1[i]) begin
				clg = 5'(i + 1);
			end
		end
		if (clg > 5'(LOG_MIN)) begin
			shamt = clg;
			kidx  = clg - 5'(LOG_MIN);
		end else begin
			shamt = 5'(LOG_MIN);
			kidx  = '0;
		end
		cls = CLS_FULL_W'(1) << shamt;
		oversize = {5'b0, req.req_size, 1'b0} > CMP_W'(CHUNK_BYTES);
		wrong = (req.req_size == '0) || ({5'b0, cls} > CMP_W'(CHUNK_BYTES / 2));
	end

	always_comb begin
		item.is_free   = (req.req_type == OP_FREE);
		item.addr      = req.block_addr;
		item.idx       = kidx[CLS_IDX_W-1:0];
		item.cls_bytes = cls;
		item.pre       = ST_OK;
		if (oversize) begin
			item.pre       = ST_OVERSIZE;
			item.cls_bytes = '0;
		end else if (wrong) begin
			item.pre       = ST_WRONG;
			item.cls_bytes = '0;
		end
	end

	assign item_valid = req_valid;
	assign req_ready  = item_ready;

endmodule

// ===== hdl/scpa_queue.sv =====
// Two-entry queue between the classifier and the allocation engine.
module scpa_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  scpa_pkg::cls_item_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output scpa_pkg::cls_item_t rd_data
);
	import scpa_pkg::*;

	localparam int DEPTH = 2;

	cls_item_t  entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'(DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/scpa_back.sv =====
// Back end: free stacks, chunk carving and the link memory.
module scpa_back #(
	parameter int CHUNK_BYTES = 32768,
	parameter int NUM_CHUNKS  = 16,
	parameter int MIN_BLOCK   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  scpa_pkg::cls_item_t item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output scpa_pkg::rsp_t      rsp
);
	import scpa_pkg::*;

	localparam int LOG_MIN     = $clog2(MIN_BLOCK);
	localparam int LOG_CHUNK   = $clog2(CHUNK_BYTES);
	localparam int LOG_TOP     = (LOG_CHUNK - 1 < SIZE_W) ? LOG_CHUNK - 1 : SIZE_W;
	localparam int NUM_CLASSES = (LOG_TOP >= LOG_MIN) ? LOG_TOP - LOG_MIN + 1 : 1;
	localparam int K_W         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int OFF_W       = LOG_CHUNK;
	localparam int CH_W        = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int CNT_W       = $clog2(NUM_CHUNKS + 1);
	localparam int LINK_AW     = ADDR_W - LOG_MIN;
	localparam int LINK_W      = ADDR_W + 1;

	typedef enum logic {S_RUN, S_POP} state_t;

	state_t              state_q;
	rsp_t                out_q;
	logic                out_vld_q;
	logic [ADDR_W-1:0]   head_addr_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] head_vld_q;
	logic [CH_W-1:0]     carve_chunk_q [NUM_CLASSES];
	logic [OFF_W-1:0]    carve_off_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] carve_vld_q;
	logic [NUM_CLASSES-1:0] used_q;
	logic [CNT_W-1:0]    chunks_q;
	logic [K_W-1:0]      pop_idx_q;
	logic [ADDR_W-1:0]   pop_addr_q;
	logic [CLSB_W-1:0]   pop_cls_q;
	logic [LINK_W-1:0]   link_mem [2**LINK_AW];
	logic [LINK_W-1:0]   link_rd_q;

	logic [K_W-1:0]      ki;
	logic                out_free;
	logic                take;
	logic                is_ok;
	logic [OFF_W-1:0]    cls_o;
	logic [CLSB_W-1:0]   cls_b;
	logic                claim;
	logic                have_blk;
	logic [CH_W-1:0]     cur_chunk;
	logic [OFF_W-1:0]    cur_off;
	logic [ADDR_W+CH_W+OFF_W-1:0] carve_wide;
	logic [OFF_W:0]      next_off;
	logic                carve_keep;
	logic                do_free;
	logic                do_pop;
	logic                do_carve;
	rsp_t                rsp_n;

	assign ki         = item.idx[K_W-1:0];
	assign out_free   = !out_vld_q || rsp_ready;
	assign item_ready = (state_q == S_RUN) && out_free;
	assign take       = item_valid && item_ready;
	assign is_ok      = (item.pre == ST_OK);
	assign cls_o      = OFF_W'(item.cls_bytes);
	assign cls_b      = item.cls_bytes[CLSB_W-1:0];
	assign claim      = !carve_vld_q[ki] && (chunks_q < CNT_W'(NUM_CHUNKS));
	assign have_blk   = carve_vld_q[ki] || claim;
	assign cur_chunk  = carve_vld_q[ki] ? carve_chunk_q[ki] : chunks_q[CH_W-1:0];
	assign cur_off    = carve_vld_q[ki] ? carve_off_q[ki] : '0;
	assign carve_wide = {ADDR_W'(0), cur_chunk, cur_off};
	assign next_off   = {1'b0, cur_off} + {1'b0, cls_o};
	assign carve_keep = ({1'b0, next_off} + {2'b0, cls_o}) <= (OFF_W + 2)'(CHUNK_BYTES);

	assign do_free  = take && is_ok && item.is_free && used_q[ki];
	assign do_pop   = take && is_ok && !item.is_free && head_vld_q[ki];
	assign do_carve = take && is_ok && !item.is_free && !head_vld_q[ki] && have_blk;

	always_comb begin
		rsp_n.status      = item.pre;
		rsp_n.alloc_addr  = '0;
		rsp_n.class_bytes = cls_b;
		if (is_ok) begin
			if (item.is_free) begin
				rsp_n.status = used_q[ki] ? ST_OK : ST_UNUSED;
			end else if (have_blk) begin
				rsp_n.alloc_addr = carve_wide[ADDR_W-1:0];
			end else begin
				rsp_n.status = ST_OOM;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			out_vld_q   <= 1'b0;
			out_q       <= '0;
			head_vld_q  <= '0;
			carve_vld_q <= '0;
			used_q      <= '0;
			chunks_q    <= '0;
		end else begin
			if (out_vld_q && rsp_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					if (take) begin
						if (is_ok && !item.is_free) begin
							used_q[ki] <= 1'b1;
						end
						if (do_free) begin
							head_vld_q[ki] <= 1'b1;
						end
						if (do_pop) begin
							state_q <= S_POP;
						end else begin
							out_vld_q <= 1'b1;
							out_q     <= rsp_n;
						end
						if (is_ok && !item.is_free && !head_vld_q[ki]) begin
							if (claim) begin
								chunks_q <= chunks_q + CNT_W'(1);
							end
							if (have_blk) begin
								carve_vld_q[ki] <= carve_keep;
							end
						end
					end
				end
				S_POP: begin
					head_vld_q[pop_idx_q] <= link_rd_q[ADDR_W];
					out_vld_q             <= 1'b1;
					out_q.status          <= ST_OK;
					out_q.alloc_addr      <= pop_addr_q;
					out_q.class_bytes     <= pop_cls_q;
					state_q               <= S_RUN;
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_free) begin
			head_addr_q[ki] <= item.addr;
		end
		if (do_carve) begin
			carve_chunk_q[ki] <= cur_chunk;
			carve_off_q[ki]   <= next_off[OFF_W-1:0];
		end
		if (do_pop) begin
			pop_idx_q  <= ki;
			pop_addr_q <= head_addr_q[ki];
			pop_cls_q  <= cls_b;
		end
		if (state_q == S_POP) begin
			head_addr_q[pop_idx_q] <= link_rd_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_free) begin
			link_mem[item.addr[ADDR_W-1:LOG_MIN]] <= {head_vld_q[ki], head_addr_q[ki]};
		end
		if (do_pop) begin
			link_rd_q <= link_mem[head_addr_q[ki][ADDR_W-1:LOG_MIN]];
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench for the size-class pool allocator: directed table plus random requests.
`timescale 1ns / 1ps

module testbench;
	import scpa_pkg::*;

	localparam int CHUNK_BYTES = 32768;
	localparam int NUM_CHUNKS  = 16;
	localparam int MIN_BLOCK   = 8;
	localparam int HALF_CHUNK  = CHUNK_BYTES / 2;
	localparam int NCLS        = 12;
	localparam int LINKS       = (1 << ADDR_W) / MIN_BLOCK;
	localparam int RANDOM_REQS = 800;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} directed_row_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		int                bytes;
	} live_block_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_bus;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// allocator image kept by the predictor
	logic [ADDR_W-1:0] head_addr [0:NCLS-1];
	bit                head_ok   [0:NCLS-1];
	logic [ADDR_W:0]   carve_at  [0:NCLS-1];
	bit                carve_ok  [0:NCLS-1];
	bit                class_seen[0:NCLS-1];
	logic [ADDR_W-1:0] link_addr [0:LINKS-1];
	bit                link_ok   [0:LINKS-1];
	int                chunks_claimed;

	rsp_t          pending_rsps[$];
	live_block_t   live_blocks[$];
	directed_row_t directed_rows[$];
	rsp_t          head_want;
	int            errors;
	int            reqs_sent;
	int            rsps_seen;
	int            status_count[0:7];
	int            burst_left;
	int            rdy_phase;

	size_class_pool_allocator #(
		.CHUNK_BYTES(CHUNK_BYTES),
		.NUM_CHUNKS (NUM_CHUNKS),
		.MIN_BLOCK  (MIN_BLOCK)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req_bus),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TIMEOUT with %0d responses outstanding", pending_rsps.size());
		$display("size_class_pool_allocator verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0h expected %0h (response %0d, t=%0t)",
			what, got, want, rsps_seen, $realtime);
		errors++;
	endtask

	function automatic void classify(input logic [SIZE_W-1:0] size, output int idx,
		output int bytes, output status_t why);
		idx = 0;
		bytes = 0;
		if (size > HALF_CHUNK) begin
			why = ST_OVERSIZE;
		end else if (size == 0) begin
			why = ST_WRONG;
		end else begin
			bytes = MIN_BLOCK;
			while (bytes < size) begin
				bytes = bytes * 2;
				idx++;
			end
			why = ST_OK;
		end
	endfunction

	function automatic rsp_t allocator_step(input req_t r);
		int      idx;
		int      bytes;
		int      off;
		int      li;
		status_t why;
		rsp_t    res;
		classify(r.req_size, idx, bytes, why);
		res.status = why;
		res.alloc_addr = '0;
		res.class_bytes = bytes[CLSB_W-1:0];
		if (why != ST_OK)
			return res;
		if (r.req_type == OP_FREE) begin
			if (!class_seen[idx]) begin
				res.status = ST_UNUSED;
			end else begin
				li = r.block_addr / MIN_BLOCK;
				link_addr[li] = head_addr[idx];
				link_ok[li] = head_ok[idx];
				head_addr[idx] = r.block_addr;
				head_ok[idx] = 1'b1;
			end
		end else begin
			class_seen[idx] = 1'b1;
			if (head_ok[idx]) begin
				res.alloc_addr = head_addr[idx];
				li = head_addr[idx] / MIN_BLOCK;
				head_addr[idx] = link_addr[li];
				head_ok[idx] = link_ok[li];
			end else begin
				if (!carve_ok[idx] && chunks_claimed < NUM_CHUNKS) begin
					carve_at[idx] = (ADDR_W+1)'(chunks_claimed * CHUNK_BYTES);
					carve_ok[idx] = 1'b1;
					chunks_claimed++;
				end
				if (carve_ok[idx]) begin
					off = int'(carve_at[idx]) % CHUNK_BYTES;
					res.alloc_addr = carve_at[idx][ADDR_W-1:0];
					carve_at[idx] = carve_at[idx] + (ADDR_W+1)'(bytes);
					if (off + 2 * bytes > CHUNK_BYTES)
						carve_ok[idx] = 1'b0;
				end else begin
					res.status = ST_OOM;
				end
			end
		end
		return res;
	endfunction

	function automatic int size_for_bytes(input int bytes);
		if (bytes == MIN_BLOCK)
			return $urandom_range(1, MIN_BLOCK);
		return $urandom_range(bytes / 2 + 1, bytes);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   roll;
		int   pick;
		int   bytes;
		roll = $urandom_range(0, 99);
		bytes = MIN_BLOCK << $urandom_range(0, NCLS - 1);
		r.req_type = OP_ALLOC;
		r.block_addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
		r.req_size = SIZE_W'(size_for_bytes(bytes));
		if (roll >= 45 && roll < 82 && live_blocks.size() != 0) begin
			pick = $urandom_range(0, live_blocks.size() - 1);
			r.req_type = OP_FREE;
			r.block_addr = live_blocks[pick].addr;
			r.req_size = SIZE_W'(size_for_bytes(live_blocks[pick].bytes));
			// keep a few so they get freed twice
			if ($urandom_range(0, 9) != 0)
				live_blocks.delete(pick);
		end else if (roll >= 82 && roll < 92) begin
			r.req_type = OP_FREE;
		end else if (roll >= 92) begin
			r.req_type = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				r.req_size = '0;
			else
				r.req_size = SIZE_W'($urandom_range(HALF_CHUNK + 1, (1 << SIZE_W) - 1));
		end
		return r;
	endfunction

	function automatic void add_row(input logic op, input int size, input int addr,
		input bit typed, input status_t st, input int aaddr, input int cbytes);
		directed_row_t row;
		row.r.req_type = op;
		row.r.req_size = SIZE_W'(size);
		row.r.block_addr = ADDR_W'(addr);
		row.typed = typed;
		row.want.status = st;
		row.want.alloc_addr = ADDR_W'(aaddr);
		row.want.class_bytes = CLSB_W'(cbytes);
		directed_rows = {directed_rows, row};
	endfunction

	task automatic issue(input req_t r, input bit typed, input rsp_t want);
		rsp_t exp;
		live_block_t blk;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 12);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_bus <= r;
		do @(posedge clk); while (!req_ready);
		exp = allocator_step(r);
		if (r.req_type == OP_ALLOC && exp.status == ST_OK) begin
			blk.addr = exp.alloc_addr;
			blk.bytes = int'(exp.class_bytes);
			live_blocks = {live_blocks, blk};
		end
		pending_rsps = {pending_rsps, typed ? want : exp};
		reqs_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("response with no request outstanding", rsp, 0);
			end else begin
				head_want = pending_rsps.pop_front();
				if (rsp.status !== head_want.status)
					report_mismatch("status", rsp.status, head_want.status);
				if (rsp.alloc_addr !== head_want.alloc_addr)
					report_mismatch("alloc_addr", rsp.alloc_addr, head_want.alloc_addr);
				if (rsp.class_bytes !== head_want.class_bytes)
					report_mismatch("class_bytes", rsp.class_bytes, head_want.class_bytes);
			end
			status_count[rsp.status]++;
			rsps_seen++;
		end
	end

	initial begin
		int mode;
		rsp_ready <= 1'b0;
		rdy_phase = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(16, 96)) begin
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 1) == 1);
					2: rsp_ready <= (rdy_phase % 3 == 0);
					default: rsp_ready <= ($urandom_range(0, 19) != 0);
				endcase
				rdy_phase++;
				@(posedge clk);
			end
		end
	end

	initial begin
		rsp_t blank;
		blank = '0;
		errors = 0;
		reqs_sent = 0;
		rsps_seen = 0;
		burst_left = 0;
		chunks_claimed = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_bus <= '0;

		add_row(OP_ALLOC, 0,     0,       1, ST_WRONG,    0, 0);
		add_row(OP_FREE,  0,     'h12345, 1, ST_WRONG,    0, 0);
		add_row(OP_ALLOC, 65535, 0,       1, ST_OVERSIZE, 0, 0);
		add_row(OP_FREE,  16385, 'h7FFFF, 1, ST_OVERSIZE, 0, 0);
		add_row(OP_ALLOC, 16385, 0,       1, ST_OVERSIZE, 0, 0);
		add_row(OP_FREE,  8,     0,       1, ST_UNUSED,   0, 8);
		add_row(OP_FREE,  16384, 'h7FFFF, 1, ST_UNUSED,   0, 16384);
		add_row(OP_ALLOC, 1,     'h7FFFF, 1, ST_OK,       0, 8);
		add_row(OP_ALLOC, 8,     0,       1, ST_OK,       8, 8);
		add_row(OP_ALLOC, 9,     0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16384, 0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16384, 0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16383, 0,       0, ST_OK,       0, 0);
		add_row(OP_FREE,  5,     8,       1, ST_OK,       0, 8);
		add_row(OP_FREE,  8,     'h7FFFF, 1, ST_OK,       0, 8);
		add_row(OP_ALLOC, 8,     0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 8,     0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 8,     0,       0, ST_OK,       0, 0);
		add_row(OP_FREE,  16384, 'h10000, 1, ST_OK,       0, 16384);
		add_row(OP_FREE,  16384, 'h10000, 0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16384, 0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16384, 0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 16384, 0,       0, ST_OK,       0, 0);
		add_row(OP_ALLOC, 4096,  0,       0, ST_OK,       0, 0);
		// misaligned free sharing a link slot with an earlier one
		add_row(OP_FREE,  1,     'h7FFF9, 0, ST_OK,       0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
		repeat (RANDOM_REQS)
			issue(random_request(), 1'b0, blank);
		req_valid <= 1'b0;

		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d requests (%0d table rows), %0d responses; %0d of %0d chunks claimed",
			reqs_sent, directed_rows.size(), rsps_seen, chunks_claimed, NUM_CHUNKS);
		$display("Status mix: ok %0d, oversize %0d, zero size %0d, out of memory %0d, unused %0d",
			status_count[ST_OK], status_count[ST_OVERSIZE], status_count[ST_WRONG],
			status_count[ST_OOM], status_count[ST_UNUSED]);
		if (errors == 0)
			$display("size_class_pool_allocator verification clean");
		else
			$display("size_class_pool_allocator verification failed");
		$finish;
	end

endmodule
